>>> hdl/bpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_pkg
// Shared types and constants for the beep pattern generator.
// ----------------------------------------------------------------------------
package bpg_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned TICKS_W = TIME_W + 1;

    localparam logic [TICKS_W-1:0] START_DELAY = TICKS_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    // Start settings, packed as on the input tdata (last field lowest)
    typedef struct packed {
        logic [COUNT_W-1:0] extra_groups;
        logic [TIME_W-1:0]  group_gap;
        logic [COUNT_W-1:0] beeps_per_group;
        logic [TIME_W-1:0]  off_period;
        logic [TIME_W-1:0]  on_time;
    } settings_t;

    typedef struct packed {
        logic pattern_active;
        logic buzzer_drive;
    } status_t;

endpackage

>>> hdl/bpg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_core
// Pattern state registers and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module bpg_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         cmd,
    input  bpg_pkg::settings_t settings,
    output bpg_pkg::status_t   status_next
);

    logic                                  active_reg,      active_next;
    logic                                  sounding_reg,    sounding_next;
    logic [bpg_pkg::COUNT_W-1:0]           beeps_left_reg,  beeps_left_next;
    logic [bpg_pkg::COUNT_W-1:0]           groups_left_reg, groups_left_next;
    logic [bpg_pkg::TICKS_W-1:0]           ticks_left_reg,  ticks_left_next;
    logic [bpg_pkg::TIME_W-1:0]            on_time_reg,     on_time_next;
    logic [bpg_pkg::TIME_W-1:0]            off_period_reg,  off_period_next;
    logic [bpg_pkg::COUNT_W-1:0]           group_size_reg,  group_size_next;
    logic [bpg_pkg::TIME_W-1:0]            gap_reg,         gap_next;
    logic [bpg_pkg::TICKS_W-1:0]           gap_plus_off;

    assign gap_plus_off = {1'b0, gap_reg} + {1'b0, off_period_reg};

    always_comb
    begin
        active_next      = active_reg;
        sounding_next    = sounding_reg;
        beeps_left_next  = beeps_left_reg;
        groups_left_next = groups_left_reg;
        ticks_left_next  = ticks_left_reg;
        on_time_next     = on_time_reg;
        off_period_next  = off_period_reg;
        group_size_next  = group_size_reg;
        gap_next         = gap_reg;

        unique case (cmd)
            bpg_pkg::CMD_TICK:
            begin
                if (active_reg)
                begin
                    if (ticks_left_reg <= bpg_pkg::TICKS_W'(1))
                    begin
                        if (!sounding_reg)
                        begin
                            sounding_next   = 1'b1;
                            beeps_left_next = beeps_left_reg - bpg_pkg::COUNT_W'(1);
                            ticks_left_next = {1'b0, on_time_reg};
                        end
                        else
                        begin
                            sounding_next = 1'b0;
                            if (beeps_left_reg != '0)
                            begin
                                ticks_left_next = {1'b0, off_period_reg};
                            end
                            else if (groups_left_reg != '0)
                            begin
                                groups_left_next = groups_left_reg - bpg_pkg::COUNT_W'(1);
                                beeps_left_next  = group_size_reg;
                                ticks_left_next  = gap_plus_off;
                            end
                            else
                            begin
                                active_next     = 1'b0;
                                ticks_left_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        ticks_left_next = ticks_left_reg - bpg_pkg::TICKS_W'(1);
                    end
                end
            end
            bpg_pkg::CMD_START:
            begin
                active_next      = 1'b1;
                sounding_next    = 1'b0;
                on_time_next     = settings.on_time;
                off_period_next  = settings.off_period;
                group_size_next  = settings.beeps_per_group;
                beeps_left_next  = settings.beeps_per_group;
                gap_next         = settings.group_gap;
                groups_left_next = settings.extra_groups;
                ticks_left_next  = bpg_pkg::START_DELAY;
            end
            bpg_pkg::CMD_STOP:
            begin
                active_next      = 1'b0;
                sounding_next    = 1'b0;
                beeps_left_next  = '0;
                groups_left_next = '0;
                ticks_left_next  = '0;
                on_time_next     = '0;
                off_period_next  = '0;
                group_size_next  = '0;
                gap_next         = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign status_next.buzzer_drive   = sounding_next;
    assign status_next.pattern_active = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            sounding_reg    <= 1'b0;
            beeps_left_reg  <= '0;
            groups_left_reg <= '0;
            ticks_left_reg  <= '0;
            on_time_reg     <= '0;
            off_period_reg  <= '0;
            group_size_reg  <= '0;
            gap_reg         <= '0;
        end
        else if (step)
        begin
            active_reg      <= active_next;
            sounding_reg    <= sounding_next;
            beeps_left_reg  <= beeps_left_next;
            groups_left_reg <= groups_left_next;
            ticks_left_reg  <= ticks_left_next;
            on_time_reg     <= on_time_next;
            off_period_reg  <= off_period_next;
            group_size_reg  <= group_size_next;
            gap_reg         <= gap_next;
        end
    end

endmodule

>>> hdl/beep_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_generator
// Buzzer beep pattern generator stepped by 1 ms tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per tick, start or stop command.
//     s_tuser carries the command, s_tdata the start settings.
//   Master channel: one transaction per input transaction, reporting
//     buzzer drive and pattern activity after that input.
//   Result path: an accepted input waits in the input register, then
//     its state update is written to the result register.
//   Throughput: 1 transaction per cycle while m_tready stays high; the
//     state update is one pass of counter logic between the input and result registers.
//   Reset: pattern idle, buzzer off, both registers empty.
//   Stall: with m_tready low the result register holds; the input
//     register still fills, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module beep_pattern_generator
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // on_time, off_period, beeps_per_group, group_gap, extra_groups
    input  logic [1:0]  s_tuser,   // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // buzzer_drive, pattern_active, zero pad
);

    logic                 in_valid_reg;
    logic [1:0]           cmd_reg;
    bpg_pkg::settings_t   settings_reg;
    logic                 out_valid_reg;
    bpg_pkg::status_t     status_reg;
    bpg_pkg::status_t     status_next;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bpg_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cmd         (cmd_reg),
        .settings    (settings_reg),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg      <= s_tuser;
            settings_reg <= bpg_pkg::settings_t'(s_tdata);
        end
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, status_reg.pattern_active, status_reg.buzzer_drive};

`ifndef SYNTHESIS
    a_buzz_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("buzzer on without active pattern");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == bpg_pkg::CMD_START) |=> (m_tdata[1] && !m_tdata[0]))
        else $error("start did not give active silent result");

    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == bpg_pkg::CMD_STOP) |=> (!m_tdata[1] && !m_tdata[0]))
        else $error("stop did not silence pattern");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");
`endif

endmodule

>>> verif/bpg_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpg_status_checker
// Watches both stream channels of the beep pattern generator. Every accepted
// input transaction is run through a local copy of the pattern state machine
// and the expected buzzer status is queued. Every accepted output transaction
// is compared against the oldest queued status.
// ----------------------------------------------------------------------------
module bpg_status_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,

    output int          errors,
    output int          outstanding,
    output int          checked
);

    bpg_pkg::status_t            status_due[$];

    logic                        pat_active;
    logic                        buzzing;
    logic [bpg_pkg::COUNT_W-1:0] beeps_left;
    logic [bpg_pkg::COUNT_W-1:0] groups_left;
    logic [bpg_pkg::TICKS_W-1:0] ticks_left;
    logic [bpg_pkg::TIME_W-1:0]  on_ms;
    logic [bpg_pkg::TIME_W-1:0]  off_ms;
    logic [bpg_pkg::COUNT_W-1:0] group_size;
    logic [bpg_pkg::TIME_W-1:0]  gap_ms;

    function automatic void clear_pattern();
        pat_active  = 1'b0;
        buzzing     = 1'b0;
        beeps_left  = '0;
        groups_left = '0;
        ticks_left  = '0;
        on_ms       = '0;
        off_ms      = '0;
        group_size  = '0;
        gap_ms      = '0;
    endfunction

    function automatic bpg_pkg::status_t step_pattern(input logic [bpg_pkg::CMD_W-1:0] cmd,
                                                      input bpg_pkg::settings_t st);
        bpg_pkg::status_t res;
        case (cmd)
            bpg_pkg::CMD_TICK:
            begin
                if (pat_active)
                begin
                    if (ticks_left > bpg_pkg::TICKS_W'(1))
                        ticks_left = ticks_left - bpg_pkg::TICKS_W'(1);
                    else if (!buzzing)
                    begin
                        buzzing    = 1'b1;
                        beeps_left = beeps_left - bpg_pkg::COUNT_W'(1);
                        ticks_left = bpg_pkg::TICKS_W'(on_ms);
                    end
                    else
                    begin
                        buzzing = 1'b0;
                        if (beeps_left != '0)
                            ticks_left = bpg_pkg::TICKS_W'(off_ms);
                        else if (groups_left != '0)
                        begin
                            groups_left = groups_left - bpg_pkg::COUNT_W'(1);
                            beeps_left  = group_size;
                            // 17-bit sum, cannot overflow
                            ticks_left  = bpg_pkg::TICKS_W'(gap_ms)
                                        + bpg_pkg::TICKS_W'(off_ms);
                        end
                        else
                        begin
                            pat_active = 1'b0;
                            ticks_left = '0;
                        end
                    end
                end
            end
            bpg_pkg::CMD_START:
            begin
                pat_active  = 1'b1;
                buzzing     = 1'b0;
                on_ms       = st.on_time;
                off_ms      = st.off_period;
                group_size  = st.beeps_per_group;
                beeps_left  = st.beeps_per_group;
                gap_ms      = st.group_gap;
                groups_left = st.extra_groups;
                ticks_left  = bpg_pkg::START_DELAY;
            end
            bpg_pkg::CMD_STOP:
            begin
                if (pat_active)
                    clear_pattern();
            end
            default:
            begin
            end
        endcase
        res.buzzer_drive   = buzzing;
        res.pattern_active = pat_active;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bpg_pkg::status_t got;
        bpg_pkg::status_t want;
        if (!rst_n)
        begin
            clear_pattern();
            status_due.delete();
            errors      = 0;
            checked     = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_due.push_back(step_pattern(s_tuser, bpg_pkg::settings_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                got = bpg_pkg::status_t'(m_tdata[1:0]);
                if (status_due.size() == 0)
                begin
                    $error("output transaction with nothing pending: m_tdata=%0h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    checked++;
                    if (got.buzzer_drive !== want.buzzer_drive)
                    begin
                        $error("buzzer_drive: expected %0b, got %0b",
                               want.buzzer_drive, got.buzzer_drive);
                        errors++;
                    end
                    if (got.pattern_active !== want.pattern_active)
                    begin
                        $error("pattern_active: expected %0b, got %0b",
                               want.pattern_active, got.pattern_active);
                        errors++;
                    end
                end
            end
            outstanding <= status_due.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the beep pattern generator. A short directed
// sequence hits idle commands, single beeps, zero durations, group reloads,
// field extremes and restarts; then random start/tick sequences mixed with
// stops, reserved codes and noise run under three back-pressure mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int                        RESET_CYCLES   = 5;
    localparam int                        WATCHDOG_LIMIT = 2000;
    localparam int                        HOLD_CYCLES    = 200;
    localparam int                        TAIL_CYCLES    = 8;
    localparam int                        PHASE_ITEMS    = 340;
    localparam logic [bpg_pkg::CMD_W-1:0] CMD_RESERVED   = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    int          errors;
    int          outstanding;
    int          checked;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_pending;
    int          n_ticks;
    int          n_starts;
    int          n_stops;
    int          n_reserved;

    beep_pattern_generator DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bpg_status_checker u_status_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bpg_pkg::settings_t make_settings(
        input logic [bpg_pkg::TIME_W-1:0]  on_t,
        input logic [bpg_pkg::TIME_W-1:0]  off_t,
        input logic [bpg_pkg::COUNT_W-1:0] beeps,
        input logic [bpg_pkg::TIME_W-1:0]  gap,
        input logic [bpg_pkg::COUNT_W-1:0] extra);
        bpg_pkg::settings_t st;
        st.on_time         = on_t;
        st.off_period      = off_t;
        st.beeps_per_group = beeps;
        st.group_gap       = gap;
        st.extra_groups    = extra;
        return st;
    endfunction

    // Mostly short patterns that can finish; now and then a full-range field
    function automatic bpg_pkg::settings_t rand_settings();
        bpg_pkg::settings_t st;
        st = make_settings(bpg_pkg::TIME_W'($urandom_range(3)),
                           bpg_pkg::TIME_W'($urandom_range(3)),
                           ($urandom_range(9) == 0) ? '0
                                                    : bpg_pkg::COUNT_W'($urandom_range(3, 1)),
                           bpg_pkg::TIME_W'($urandom_range(3)),
                           bpg_pkg::COUNT_W'($urandom_range(2)));
        if ($urandom_range(4) == 0) st.on_time         = bpg_pkg::TIME_W'($urandom);
        if ($urandom_range(4) == 0) st.off_period      = bpg_pkg::TIME_W'($urandom);
        if ($urandom_range(9) == 0) st.beeps_per_group = bpg_pkg::COUNT_W'($urandom);
        if ($urandom_range(4) == 0) st.group_gap       = bpg_pkg::TIME_W'($urandom);
        if ($urandom_range(9) == 0) st.extra_groups    = bpg_pkg::COUNT_W'($urandom);
        return st;
    endfunction

    function automatic bpg_pkg::settings_t rand_bits();
        return bpg_pkg::settings_t'({$urandom, $urandom});
    endfunction

    task automatic send(input logic [bpg_pkg::CMD_W-1:0] cmd, input bpg_pkg::settings_t st);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= st;
        do @(posedge clk); while (!s_tready);
        case (cmd)
            bpg_pkg::CMD_TICK:  n_ticks++;
            bpg_pkg::CMD_START: n_starts++;
            bpg_pkg::CMD_STOP:  n_stops++;
            default:            n_reserved++;
        endcase
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit hold);
        int                        sent;
        int                        n;
        int                        r;
        logic [bpg_pkg::CMD_W-1:0] cmd;
        tx_idle_pct  = tx_pct;
        rx_idle_pct  = rx_pct;
        hold_pending = hold;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                send(bpg_pkg::CMD_START, rand_settings());
                sent++;
                n = $urandom_range(80, 5);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 3)
                        cmd = bpg_pkg::CMD_STOP;
                    else if (r < 5)
                        cmd = CMD_RESERVED;
                    else if (r < 7)
                        cmd = bpg_pkg::CMD_START;
                    else
                        cmd = bpg_pkg::CMD_TICK;
                    send(cmd, (cmd == bpg_pkg::CMD_START) ? rand_settings() : rand_bits());
                    if (cmd != CMD_RESERVED)
                        sent++;
                end
            end
            else
            begin
                n = $urandom_range(15, 3);
                repeat (n)
                begin
                    cmd = bpg_pkg::CMD_W'($urandom_range(3));
                    send(cmd, rand_bits());
                    if (cmd != CMD_RESERVED)
                        sent++;
                end
            end
        end
        wait_results();
    endtask

    // Receiver: random ready, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = bpg_pkg::CMD_TICK;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_pending = 1'b0;
        n_ticks      = 0;
        n_starts     = 0;
        n_stops      = 0;
        n_reserved   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle commands
        send(bpg_pkg::CMD_TICK, '0);
        send(bpg_pkg::CMD_STOP, '1);
        send(CMD_RESERVED, '1);
        // single beep, runs to completion
        send(bpg_pkg::CMD_START, make_settings(16'd2, 16'd1, 8'd1, 16'd0, 8'd0));
        repeat (3) send(bpg_pkg::CMD_TICK, '0);
        // zero durations, two beeps, one extra group
        send(bpg_pkg::CMD_START, make_settings(16'd0, 16'd0, 8'd2, 16'd0, 8'd1));
        repeat (8) send(bpg_pkg::CMD_TICK, '0);
        // all-ones fields, reserved code mid-pattern, restart with zero beeps, stop
        send(bpg_pkg::CMD_START, make_settings('1, '1, '1, '1, '1));
        repeat (2) send(bpg_pkg::CMD_TICK, '0);
        send(CMD_RESERVED, '0);
        send(bpg_pkg::CMD_START, make_settings(16'd0, 16'd0, 8'd0, 16'd0, 8'd0));
        repeat (2) send(bpg_pkg::CMD_TICK, '1);
        send(bpg_pkg::CMD_STOP, '0);
        send(bpg_pkg::CMD_STOP, '0);
        wait_results();

        run_phase(11, 72, 1'b0);
        run_phase(72, 11, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d ticks, %0d starts, %0d stops, %0d reserved commands",
                 n_ticks, n_starts, n_stops, n_reserved);
        $display("%0d status transactions compared over three stall mixes and one long output hold",
                 checked);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> beep_pattern_generator.f
hdl/bpg_pkg.sv
hdl/bpg_core.sv
hdl/beep_pattern_generator.sv
verif/bpg_status_checker.sv
verif/tb.sv
